[rtl/de9_gamepad_select_reader_unit_assert.svh]
// ----------------------------------------------------------------------------
// DE-9 pad reader assertion macros
// Concurrent check helpers, clocked on aclk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DE9_GAMEPAD_SELECT_READER_UNIT_ASSERT_SVH
`define DE9_GAMEPAD_SELECT_READER_UNIT_ASSERT_SVH

// same-cycle implication
`define DE9GP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DE9GP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/de9gp_pkg.sv]
// ----------------------------------------------------------------------------
// DE-9 pad reader package
// Shared types, register indexes and mode helper.
// ----------------------------------------------------------------------------
package de9gp_pkg;

    localparam int unsigned IDX_W     = 3;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned IN_W      = 8;
    localparam int unsigned OUT_W     = 24;

    typedef enum logic [IDX_W-1:0] {
        REG_HAS_SELECT   = 3'd0,
        REG_OVR_ENABLE   = 3'd1,
        REG_OVR_VALUE    = 3'd2,
        REG_SETTLE       = 3'd3,
        REG_STARTUP      = 3'd4,
        REG_POLL         = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_TWO   = 2'd0,
        MODE_THREE = 2'd1,
        MODE_SIX   = 2'd2
    } pad_mode_t;

    typedef struct packed {
        logic        has_select;
        logic        ovr_en;
        logic [1:0]  ovr_val;
        logic [15:0] settle;
        logic [15:0] startup;
        logic [19:0] poll;
    } cfg_t;

    typedef struct packed {
        logic        detecting;
        logic        change;
        logic [1:0]  mode;
        logic [11:0] buttons;
        logic        select;
    } status_t;

    function automatic logic [1:0] eff_mode(input cfg_t cfg, input logic [1:0] det);
        logic [1:0] m;
        m = cfg.ovr_en ? cfg.ovr_val : det;
        if (!cfg.has_select) begin
            return MODE_TWO;
        end
        return (m == 2'd3) ? MODE_SIX : m;
    endfunction

endpackage

[rtl/de9_gamepad_select_reader_unit.sv]
// ----------------------------------------------------------------------------
// DE-9 pad select reader, top level
// Output: the output register, the only stage, shows each result on m_ the cycle
// after acceptance; one request per cycle unless m_tvalid is high and m_tready low.
// Reset: synchronous aresetn clears the output valid flag and the sequencer,
// which restarts in the detection startup hold with select high.
// ----------------------------------------------------------------------------
`include "de9_gamepad_select_reader_unit_assert.svh"

module de9_gamepad_select_reader_unit
    import de9gp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // pad_pins[5:0], detect_request, clear_change
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // select_out, buttons[11:0], pad_mode[1:0],
                                             // change_flag, detecting, zero fill
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_q;
    status_t status;
    logic    s_accept;

    logic          out_valid_reg;
    logic          out_valid_next;
    status_t       out_data_reg;

    logic          no_sel_acc;
    logic          out_two_btn;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    de9gp_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg_q)
    );

    de9gp_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tick           (s_accept),
        .pad_pins       (s_tdata[5:0]),
        .detect_request (s_tdata[6]),
        .clear_change   (s_tdata[7]),
        .cfg            (cfg_q),
        .status         (status)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (s_accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_data_reg <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - $bits(status_t)){1'b0}}, out_data_reg};

    assign no_sel_acc  = s_accept && !cfg_q.has_select;
    assign out_two_btn = (out_data_reg.mode == MODE_TWO) && !out_data_reg.detecting;

    `DE9GP_ASSERT_NOW(a_stall_only_on_full, !s_tready, m_tvalid && !m_tready, "input stalled")
    `DE9GP_ASSERT_NEXT(a_accept_gives_result, s_accept, m_tvalid, "request lost")
    `DE9GP_ASSERT_NEXT(a_no_select_two_button, no_sel_acc, out_two_btn, "active without select")
    `DE9GP_ASSERT_NOW(a_mode_range, m_tvalid, m_tdata[14:13] != 2'd3, "pad mode out of range")

endmodule

[rtl/de9gp_cfg.sv]
// ----------------------------------------------------------------------------
// DE-9 pad reader configuration registers
// Write-only register file for select, mode override and timing.
// ----------------------------------------------------------------------------
module de9gp_cfg
    import de9gp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx_t'(wr_index))
                REG_HAS_SELECT: cfg_next.has_select = wr_data[0];
                REG_OVR_ENABLE: cfg_next.ovr_en     = wr_data[0];
                REG_OVR_VALUE:  cfg_next.ovr_val    = wr_data[1:0];
                REG_SETTLE:     cfg_next.settle     = wr_data[15:0];
                REG_STARTUP:    cfg_next.startup    = wr_data[15:0];
                REG_POLL:       cfg_next.poll       = wr_data[19:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.has_select <= 1'b1;
            cfg_reg.ovr_en     <= 1'b0;
            cfg_reg.ovr_val    <= MODE_TWO;
            cfg_reg.settle     <= 16'd150;
            cfg_reg.startup    <= 16'd3000;
            cfg_reg.poll       <= 20'd10000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/de9gp_seq.sv]
// ----------------------------------------------------------------------------
// DE-9 pad reader select sequencer
// Phase timer, poll timer, detection and button word assembly, one tick per
// request. Status reflects the state after the tick.
// ----------------------------------------------------------------------------
module de9gp_seq
    import de9gp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       tick,
    input  logic [5:0] pad_pins,
    input  logic       detect_request,
    input  logic       clear_change,
    input  cfg_t       cfg,
    output status_t    status
);

    typedef enum logic [3:0] {
        PH_DET_HOLD = 4'd0,
        PH_DET_L1   = 4'd1,
        PH_DET_H2   = 4'd2,
        PH_DET_L2   = 4'd3,
        PH_DET_H3   = 4'd4,
        PH_DET_L3   = 4'd5,
        PH_IDLE     = 4'd6,
        PH_RD_H1    = 4'd7,
        PH_RD_L1    = 4'd8,
        PH_RD_H2    = 4'd9,
        PH_RD_L2    = 4'd10,
        PH_RD_H3    = 4'd11,
        PH_RD_L3    = 4'd12,
        PH_RD_H4    = 4'd13
    } phase_t;

    function automatic logic phase_level(input phase_t p);
        case (p) inside
            PH_DET_L1, PH_DET_L2, PH_DET_L3, PH_RD_L1, PH_RD_L2, PH_RD_L3: return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

    phase_t      phase_reg,   phase_next;
    logic [15:0] pticks_reg,  pticks_next;
    logic [19:0] poll_reg,    poll_next;
    logic [11:0] staging_reg, staging_next;
    logic [11:0] button_reg,  button_next;
    logic [1:0]  det_reg,     det_next;
    logic        change_reg,  change_next;

    logic [5:0]  low;
    logic [19:0] interval;
    logic [15:0] limit;
    logic [15:0] pt_inc;
    logic        do_commit;
    logic [11:0] stage_val;

    always_comb begin
        low      = ~pad_pins;
        interval = (cfg.poll == '0) ? 20'd1 : cfg.poll;
        limit    = (phase_reg == PH_DET_HOLD) ? cfg.startup : cfg.settle;
        if (limit == '0) begin
            limit = 16'd1;
        end
        pt_inc = (pticks_reg != 16'hFFFF) ? pticks_reg + 16'd1 : pticks_reg;

        phase_next   = phase_reg;
        pticks_next  = pticks_reg;
        poll_next    = (poll_reg < interval) ? poll_reg + 20'd1 : poll_reg;
        staging_next = staging_reg;
        button_next  = button_reg;
        det_next     = det_reg;
        change_next  = clear_change ? 1'b0 : change_reg;
        do_commit    = 1'b0;
        stage_val    = staging_reg;

        if (detect_request && cfg.has_select) begin
            det_next    = MODE_TWO;
            phase_next  = PH_DET_HOLD;
            pticks_next = '0;
        end else if (phase_reg <= PH_DET_L3 && !cfg.has_select) begin
            det_next    = MODE_TWO;
            phase_next  = PH_IDLE;
            pticks_next = '0;
        end else if (phase_reg == PH_IDLE) begin
            if (poll_next >= interval) begin
                poll_next   = '0;
                phase_next  = PH_RD_H1;
                pticks_next = '0;
            end
        end else begin
            pticks_next = pt_inc;
            if (pt_inc >= limit) begin
                pticks_next = '0;
                case (phase_reg)
                    PH_DET_L1: begin
                        if (low[3:2] == 2'b11) begin
                            det_next   = MODE_THREE;
                            phase_next = PH_DET_H2;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_DET_L3: begin
                        if (low[3:0] == 4'hF) begin
                            det_next = MODE_SIX;
                        end
                        phase_next = PH_IDLE;
                    end
                    PH_RD_H1: begin
                        stage_val    = {5'd0, low[5], low[4], 1'b0, low[3:0]};
                        staging_next = stage_val;
                        if (eff_mode(cfg, det_reg) == MODE_TWO) begin
                            do_commit = 1'b1;
                        end else begin
                            phase_next = PH_RD_L1;
                        end
                    end
                    PH_RD_L1: begin
                        stage_val    = staging_reg | {4'd0, low[5], 2'd0, low[4], 4'd0};
                        staging_next = stage_val;
                        if (eff_mode(cfg, det_reg) == MODE_SIX) begin
                            phase_next = PH_RD_H2;
                        end else begin
                            do_commit = 1'b1;
                        end
                    end
                    PH_RD_H4: begin
                        stage_val    = staging_reg | {low[3], low[0], low[1], low[2], 8'd0};
                        staging_next = stage_val;
                        do_commit    = 1'b1;
                    end
                    PH_DET_HOLD, PH_DET_H2, PH_DET_L2, PH_DET_H3,
                    PH_RD_H2, PH_RD_L2, PH_RD_H3, PH_RD_L3: begin
                        phase_next = phase_t'(phase_reg + 4'd1);
                    end
                    default: phase_next = PH_IDLE;
                endcase
                if (do_commit) begin
                    if (stage_val != button_reg) begin
                        change_next = 1'b1;
                    end
                    button_next = stage_val;
                    phase_next  = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_DET_HOLD;
            pticks_reg  <= '0;
            poll_reg    <= '0;
            staging_reg <= '0;
            button_reg  <= '0;
            det_reg     <= MODE_TWO;
            change_reg  <= 1'b0;
        end else if (tick) begin
            phase_reg   <= phase_next;
            pticks_reg  <= pticks_next;
            poll_reg    <= poll_next;
            staging_reg <= staging_next;
            button_reg  <= button_next;
            det_reg     <= det_next;
            change_reg  <= change_next;
        end
    end

    always_comb begin
        status.select    = phase_level(phase_next);
        status.buttons   = button_next;
        status.mode      = eff_mode(cfg, det_next);
        status.change    = change_next;
        status.detecting = (phase_next <= PH_DET_L3);
    end

endmodule
